### rtl/vcpa_pkg.sv
// package: widths, codes and decode helpers for the velocity command arbiter
`timescale 1ns / 1ps
package vcpa_pkg;

   localparam int VALUE_WIDTH = 16;
   localparam int TIME_WIDTH  = 32;
   localparam int CFG_WIDTH   = 16;
   localparam int NUM_SRC     = 4;
   localparam int SRC_W       = $clog2(NUM_SRC);

   localparam logic [CFG_WIDTH-1:0] TIMEOUT_RESET = CFG_WIDTH'(1500);

   // row of each source in the command store and bit in the live mask
   localparam logic [SRC_W-1:0] ROW_BRAKE = SRC_W'(0);
   localparam logic [SRC_W-1:0] ROW_STOP  = SRC_W'(1);
   localparam logic [SRC_W-1:0] ROW_LANE  = SRC_W'(2);
   localparam logic [SRC_W-1:0] ROW_MAP   = SRC_W'(3);

   typedef enum logic [2:0] {
      ACT_TICK       = 3'd0,
      ACT_BRAKE_CMD  = 3'd1,
      ACT_STOP_CMD   = 3'd2,
      ACT_LANE_CMD   = 3'd3,
      ACT_MAP_CMD    = 3'd4,
      ACT_STOP_FLAG  = 3'd5,
      ACT_ROUND_FLAG = 3'd6
   } action_type;

   typedef enum logic [2:0] {
      CODE_SAFETY = 3'd0,
      CODE_BRAKE  = 3'd1,
      CODE_STOP   = 3'd2,
      CODE_MAP    = 3'd3,
      CODE_ROUND  = 3'd4,
      CODE_LANE   = 3'd5
   } src_code_type;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;

   typedef struct packed {
      value_type ang_z;
      value_type ang_y;
      value_type ang_x;
      value_type lin_z;
      value_type lin_y;
      value_type lin_x;
   } cmd_row_type;

   // winner of one tick: which row to read and what to report
   typedef struct packed {
      logic [SRC_W-1:0] row;
      src_code_type     code;
   } sel_type;

   function automatic logic is_cmd(input logic [2:0] act);
      logic r;
      case (act) inside
         ACT_BRAKE_CMD, ACT_STOP_CMD, ACT_LANE_CMD, ACT_MAP_CMD: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic [SRC_W-1:0] cmd_row(input logic [2:0] act);
      logic [SRC_W-1:0] r;
      case (act)
         ACT_BRAKE_CMD: r = ROW_BRAKE;
         ACT_STOP_CMD:  r = ROW_STOP;
         ACT_LANE_CMD:  r = ROW_LANE;
         ACT_MAP_CMD:   r = ROW_MAP;
         default:       r = ROW_BRAKE;
      endcase
      return r;
   endfunction

endpackage

### rtl/vcpa_if.sv
// channel interfaces: request, response and control register write
`timescale 1ns / 1ps
interface vcpa_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [2:0]                           action;
   logic [vcpa_pkg::TIME_WIDTH-1:0]      now_ms;
   logic signed [vcpa_pkg::VALUE_WIDTH-1:0] lin_x;
   logic signed [vcpa_pkg::VALUE_WIDTH-1:0] lin_y;
   logic signed [vcpa_pkg::VALUE_WIDTH-1:0] lin_z;
   logic signed [vcpa_pkg::VALUE_WIDTH-1:0] ang_x;
   logic signed [vcpa_pkg::VALUE_WIDTH-1:0] ang_y;
   logic signed [vcpa_pkg::VALUE_WIDTH-1:0] ang_z;
   logic                                 flag_value;

   modport source (output valid, action, now_ms, lin_x, lin_y, lin_z, ang_x, ang_y, ang_z,
                   flag_value, input ready);
   modport sink   (input valid, action, now_ms, lin_x, lin_y, lin_z, ang_x, ang_y, ang_z,
                   flag_value, output ready);
endinterface

interface vcpa_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [vcpa_pkg::VALUE_WIDTH-1:0] out_lin_x;
   logic signed [vcpa_pkg::VALUE_WIDTH-1:0] out_lin_y;
   logic signed [vcpa_pkg::VALUE_WIDTH-1:0] out_lin_z;
   logic signed [vcpa_pkg::VALUE_WIDTH-1:0] out_ang_x;
   logic signed [vcpa_pkg::VALUE_WIDTH-1:0] out_ang_y;
   logic signed [vcpa_pkg::VALUE_WIDTH-1:0] out_ang_z;
   logic [2:0]                           source_code;
   logic                                 drive_active;

   modport source (output valid, out_lin_x, out_lin_y, out_lin_z, out_ang_x, out_ang_y,
                   out_ang_z, source_code, drive_active, input ready);
   modport sink   (input valid, out_lin_x, out_lin_y, out_lin_z, out_ang_x, out_ang_y,
                   out_ang_z, source_code, drive_active, output ready);
endinterface

interface vcpa_csr_if;
   logic                               valid;
   logic                               ready;
   logic [vcpa_pkg::CFG_WIDTH-1:0]     data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

### rtl/velocity_command_priority_arbiter.sv
// top level: request decode, command store read pipeline and response register
`timescale 1ns / 1ps
// One request is taken every cycle while the response side keeps up. Command and flag
// requests update the state and give no response. A tick ages all four sources in
// parallel against the timeout register, picks the highest-priority live command (brake,
// then stop sign while the stop flag is set, then map, then lane, else an all-zero safety
// stop) and reads that command's row from the command store. The store has a registered
// read. A tick's winner code and row data pass through the read stage and then the
// response register before the response turns valid. While a response waits for rsp
// ready, one more tick can sit in the read stage; after that, requests stall until
// the response is taken. Map and lane responses carry only linear x and angular z.
// The timeout register resets to 1500 ms and is written through the csr channel,
// which is always ready.
module velocity_command_priority_arbiter (
   input  logic        clock,
   input  logic        reset,
   vcpa_req_if.sink    req_chan,
   vcpa_rsp_if.source  rsp_chan,
   vcpa_csr_if.sink    csr_chan
);
   import vcpa_pkg::*;

   logic         req_fire;
   logic         tick_fire;
   sel_type      sel;
   cmd_row_type  wr_data;
   cmd_row_type  rd_data;
   logic         s1_valid_ff, s1_valid_in;
   src_code_type s1_code_ff;
   logic         s1_move;
   logic         rsp_valid_ff, rsp_valid_in;
   cmd_row_type  rsp_row_ff, rsp_row_in;
   src_code_type rsp_code_ff;
   logic         full_cmd;
   logic         part_cmd;

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign tick_fire = req_fire && (action_type'(req_chan.action) == ACT_TICK);

   assign s1_move        = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_move;

   assign wr_data = '{ang_z: req_chan.ang_z, ang_y: req_chan.ang_y, ang_x: req_chan.ang_x,
                      lin_z: req_chan.lin_z, lin_y: req_chan.lin_y, lin_x: req_chan.lin_x};

   vcpa_select u_select (
      .clock      (clock),
      .reset      (reset),
      .fire       (req_fire),
      .action     (req_chan.action),
      .now_ms     (req_chan.now_ms),
      .flag_value (req_chan.flag_value),
      .csr_chan   (csr_chan),
      .sel        (sel)
   );

   vcpa_cmd_ram u_cmd_ram (
      .clock   (clock),
      .wr_en   (req_fire && is_cmd(req_chan.action)),
      .wr_row  (cmd_row(req_chan.action)),
      .wr_data (wr_data),
      .rd_en   (tick_fire),
      .rd_row  (sel.row),
      .rd_data (rd_data)
   );

   always_comb begin
      if (tick_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_comb begin
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // brake and stop sign pass all six components, map and lane only x and yaw
   assign full_cmd = (s1_code_ff == CODE_BRAKE) || (s1_code_ff == CODE_STOP);
   assign part_cmd = (s1_code_ff == CODE_MAP) || (s1_code_ff == CODE_ROUND) ||
                     (s1_code_ff == CODE_LANE);

   always_comb begin
      rsp_row_in = '0;
      if (full_cmd) begin
         rsp_row_in = rd_data;
      end else if (part_cmd) begin
         rsp_row_in.lin_x = rd_data.lin_x;
         rsp_row_in.ang_z = rd_data.ang_z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tick_fire) begin
         s1_code_ff <= sel.code;
      end
      if (s1_move) begin
         rsp_row_ff  <= rsp_row_in;
         rsp_code_ff <= s1_code_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.out_lin_x    = rsp_row_ff.lin_x;
   assign rsp_chan.out_lin_y    = rsp_row_ff.lin_y;
   assign rsp_chan.out_lin_z    = rsp_row_ff.lin_z;
   assign rsp_chan.out_ang_x    = rsp_row_ff.ang_x;
   assign rsp_chan.out_ang_y    = rsp_row_ff.ang_y;
   assign rsp_chan.out_ang_z    = rsp_row_ff.ang_z;
   assign rsp_chan.source_code  = rsp_code_ff;
   assign rsp_chan.drive_active = (rsp_code_ff != CODE_SAFETY);

   // a tick transfer always lands in the read stage
   a_tick_enters_s1: assert property (@(posedge clock) disable iff (reset)
      tick_fire |=> s1_valid_ff)
      else $error("tick transfer did not reach read stage");

   // read stage never overwritten while still waiting
   a_s1_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_move) |-> !tick_fire)
      else $error("read stage overrun");

   // safety stop is all zero
   a_safety_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_code_ff == CODE_SAFETY)) |-> (rsp_row_ff == '0))
      else $error("safety stop response not zero");

   // map and lane keep the side components at zero
   a_part_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && ((rsp_code_ff == CODE_MAP) || (rsp_code_ff == CODE_ROUND) ||
                        (rsp_code_ff == CODE_LANE)))
      |-> (rsp_row_ff.lin_y == '0 && rsp_row_ff.lin_z == '0 &&
           rsp_row_ff.ang_x == '0 && rsp_row_ff.ang_y == '0))
      else $error("map or lane response carries side components");

endmodule

### rtl/vcpa_cmd_ram.sv
// command store: one row of six components per source, registered read
`timescale 1ns / 1ps
module vcpa_cmd_ram (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [vcpa_pkg::SRC_W-1:0]   wr_row,
   input  vcpa_pkg::cmd_row_type        wr_data,
   input  logic                         rd_en,
   input  logic [vcpa_pkg::SRC_W-1:0]   rd_row,
   output vcpa_pkg::cmd_row_type        rd_data
);
   import vcpa_pkg::*;

   cmd_row_type mem [NUM_SRC];
   cmd_row_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_row] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_row];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/vcpa_select.sv
// live marks, time stamps, flags and timeout register; ages sources and picks the winner
`timescale 1ns / 1ps
module vcpa_select (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            fire,
   input  logic [2:0]                      action,
   input  logic [vcpa_pkg::TIME_WIDTH-1:0] now_ms,
   input  logic                            flag_value,
   vcpa_csr_if.sink                        csr_chan,
   output vcpa_pkg::sel_type               sel
);
   import vcpa_pkg::*;

   logic [NUM_SRC-1:0]    live_ff, live_in;
   logic [TIME_WIDTH-1:0] stamp_ff [NUM_SRC];
   logic                  stop_seen_ff, stop_seen_in;
   logic                  in_circle_ff, in_circle_in;
   logic [CFG_WIDTH-1:0]  timeout_ff, timeout_in;
   logic [NUM_SRC-1:0]    stale;
   logic [NUM_SRC-1:0]    aged;
   logic [TIME_WIDTH-1:0] age [NUM_SRC];

   assign csr_chan.ready = 1'b1;

   // modular age of every source, compared in parallel
   always_comb begin
      for (int i = 0; i < NUM_SRC; i++) begin
         age[i]   = now_ms - stamp_ff[i];
         stale[i] = age[i] > TIME_WIDTH'(timeout_ff);
      end
      aged = live_ff & ~stale;
   end

   always_comb begin
      if (aged[ROW_BRAKE]) begin
         sel.row  = ROW_BRAKE;
         sel.code = CODE_BRAKE;
      end else if (aged[ROW_STOP] && stop_seen_ff) begin
         sel.row  = ROW_STOP;
         sel.code = CODE_STOP;
      end else if (aged[ROW_MAP]) begin
         sel.row  = ROW_MAP;
         sel.code = in_circle_ff ? CODE_ROUND : CODE_MAP;
      end else if (aged[ROW_LANE]) begin
         sel.row  = ROW_LANE;
         sel.code = CODE_LANE;
      end else begin
         sel.row  = ROW_BRAKE;
         sel.code = CODE_SAFETY;
      end
   end

   always_comb begin
      live_in      = live_ff;
      stop_seen_in = stop_seen_ff;
      in_circle_in = in_circle_ff;
      if (fire) begin
         case (action_type'(action))
            ACT_TICK:       live_in = aged;
            ACT_STOP_FLAG:  stop_seen_in = flag_value;
            ACT_ROUND_FLAG: in_circle_in = flag_value;
            default: begin
               if (is_cmd(action)) begin
                  live_in = live_ff | (NUM_SRC'(1) << cmd_row(action));
               end
            end
         endcase
      end
   end

   assign timeout_in = (csr_chan.valid && csr_chan.ready) ? csr_chan.data : timeout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff      <= '0;
         stop_seen_ff <= 1'b0;
         in_circle_ff <= 1'b0;
         timeout_ff   <= TIMEOUT_RESET;
      end else begin
         live_ff      <= live_in;
         stop_seen_ff <= stop_seen_in;
         in_circle_ff <= in_circle_in;
         timeout_ff   <= timeout_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && is_cmd(action)) begin
         stamp_ff[cmd_row(action)] <= now_ms;
      end
   end

endmodule
